// ===== sv/fraction_add_reduce_pkg.sv =====
package frac_add_pkg;

    // Value of reduce_enable after reset: reduce to lowest terms.
    localparam logic REDUCE_EN_RESET = 1'b1;

endpackage

// ===== sv/fraction_add_reduce.sv =====
// fraction_add_reduce: adds two signed fractions num_a/den_a + num_b/den_b and
// returns (num_a*den_b + den_a*num_b) / (den_a*den_b), optionally reduced to
// lowest terms. Signs stay where the cross products put them, so a negative
// denominator stays negative. A zero input denominator returns 0/0 with
// o_zero_den_error set.
// Input channel: i_in_valid / o_in_stall; a transfer happens at a rising edge
// with i_in_valid high and o_in_stall low. Output channel: o_out_valid /
// i_out_stall, same rule with the stall driven by the receiver.
// The shared multiplier forms the three products one after another, then the
// two cross products are added; with reduction a binary GCD runs shift or
// subtract steps, and a restoring divider divides the numerator and then the
// denominator by it. Without reduction the sum goes straight to the output
// stage; a zero denominator skips all of these steps.
// One item is in work at a time; o_in_stall stays high until it finishes.
// A finished result sits in the output register while the next item is taken;
// if the receiver still stalls when that next item finishes, hold it there.
// Reset (i_rst_n low, synchronous) drops any item in work, empties the output
// register and sets reduce_enable to 1. Write reduce_enable only while idle.
module fraction_add_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_den_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_b,
    input  logic signed [OPERAND_WIDTH-1:0] i_den_b,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [2*OPERAND_WIDTH:0] o_sum_num,
    output logic signed [2*OPERAND_WIDTH-1:0] o_sum_den,
    output logic                            o_zero_den_error
);

    localparam int W    = OPERAND_WIDTH;
    localparam int WW   = 2 * OPERAND_WIDTH;
    localparam int CW   = $clog2(WW);
    localparam logic [CW-1:0] CNT_LAST = CW'(WW - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_AD,
        S_MUL_BC,
        S_MUL_BD,
        S_SUM,
        S_GCD,
        S_DIV_N,
        S_DIV_D,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_reduce_en;

    // operand magnitudes and signs
    logic [W-1:0] r_mag_a, r_mag_b, r_mag_c, r_mag_d;
    logic         r_sgn_a, r_sgn_b, r_sgn_c, r_sgn_d;

    logic [WW-1:0] r_p1, r_p2;
    logic [WW-1:0] r_gx, r_gy;     // GCD working pair
    logic [WW-1:0] r_qn, r_qd;     // numerator / denominator magnitudes
    logic [WW-1:0] r_div, r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_nneg, r_dneg, r_err;

    logic                 r_out_valid;
    logic signed [WW:0]   r_sum_num;
    logic signed [WW-1:0] r_sum_den;
    logic                 r_out_err;

    // input magnitudes
    logic [W-1:0] mag_a, mag_b, mag_c, mag_d;
    assign mag_a = i_num_a[W-1] ? W'(-i_num_a) : i_num_a;
    assign mag_b = i_den_a[W-1] ? W'(-i_den_a) : i_den_a;
    assign mag_c = i_num_b[W-1] ? W'(-i_num_b) : i_num_b;
    assign mag_d = i_den_b[W-1] ? W'(-i_den_b) : i_den_b;

    // shared multiplier
    logic [W-1:0]  mul_x, mul_y;
    logic [WW-1:0] mul_p;
    always_comb begin
        case (r_state)
            S_MUL_AD: begin mul_x = r_mag_a; mul_y = r_mag_d; end
            S_MUL_BC: begin mul_x = r_mag_b; mul_y = r_mag_c; end
            default:  begin mul_x = r_mag_b; mul_y = r_mag_d; end
        endcase
    end
    assign mul_p = WW'(mul_x) * WW'(mul_y);

    // signed sum of the cross products, as sign and magnitude
    logic          p1neg, p2neg, sum_neg;
    logic [WW-1:0] sum_mag;
    assign p1neg = (r_sgn_a ^ r_sgn_d) && (r_p1 != '0);
    assign p2neg = (r_sgn_b ^ r_sgn_c) && (r_p2 != '0);
    always_comb begin
        if (p1neg == p2neg) begin
            sum_mag = r_p1 + r_p2;
            sum_neg = p1neg;
        end else if (r_p1 >= r_p2) begin
            sum_mag = r_p1 - r_p2;
            sum_neg = p1neg;
        end else begin
            sum_mag = r_p2 - r_p1;
            sum_neg = p2neg;
        end
    end

    // shared subtractor: GCD reduction steps and restoring division
    logic          gx_ge;
    logic [WW:0]   rem_sh;
    logic [WW:0]   sub_a, sub_b;
    logic [WW+1:0] sub_d;
    logic          div_msb, q_bit;
    assign gx_ge   = r_gx >= r_gy;
    assign div_msb = (r_state == S_DIV_D) ? r_qd[WW-1] : r_qn[WW-1];
    assign rem_sh  = {r_rem, div_msb};
    always_comb begin
        if (r_state == S_GCD) begin
            sub_a = gx_ge ? {1'b0, r_gx} : {1'b0, r_gy};
            sub_b = gx_ge ? {1'b0, r_gy} : {1'b0, r_gx};
        end else begin
            sub_a = rem_sh;
            sub_b = {1'b0, r_div};
        end
    end
    assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
    assign q_bit = ~sub_d[WW+1];

    logic          load_out;
    logic [WW-1:0] rem_next;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign rem_next = q_bit ? sub_d[WW-1:0] : rem_sh[WW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reduce_en <= frac_add_pkg::REDUCE_EN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reduce_en <= i_cfg_wdata;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag_a <= mag_a;
                        r_mag_b <= mag_b;
                        r_mag_c <= mag_c;
                        r_mag_d <= mag_d;
                        r_sgn_a <= i_num_a[W-1];
                        r_sgn_b <= i_den_a[W-1];
                        r_sgn_c <= i_num_b[W-1];
                        r_sgn_d <= i_den_b[W-1];
                        if (i_den_a == '0 || i_den_b == '0) begin
                            // zero denominator: drop straight to a 0/0 error result
                            r_qn    <= '0;
                            r_qd    <= '0;
                            r_nneg  <= 1'b0;
                            r_dneg  <= 1'b0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_err   <= 1'b0;
                            r_state <= S_MUL_AD;
                        end
                    end
                end
                S_MUL_AD: begin
                    r_p1    <= mul_p;
                    r_state <= S_MUL_BC;
                end
                S_MUL_BC: begin
                    r_p2    <= mul_p;
                    r_state <= S_MUL_BD;
                end
                S_MUL_BD: begin
                    r_qd    <= mul_p;
                    r_gy    <= mul_p;
                    r_dneg  <= r_sgn_b ^ r_sgn_d;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_qn    <= sum_mag;
                    r_gx    <= sum_mag;
                    r_nneg  <= sum_neg && (sum_mag != '0);
                    r_state <= r_reduce_en ? S_GCD : S_DONE;
                end
                S_GCD: begin
                    if (r_gx == '0 || r_gy == '0) begin
                        // one side is zero: the other is the GCD left after any common factors of two were taken out
                        r_div   <= r_gx | r_gy;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_N;
                    end else if (!r_gx[0] && !r_gy[0]) begin
                        // common factor of two: take it out of the results directly
                        r_gx <= r_gx >> 1;
                        r_gy <= r_gy >> 1;
                        r_qn <= r_qn >> 1;
                        r_qd <= r_qd >> 1;
                    end else if (!r_gx[0]) begin
                        r_gx <= r_gx >> 1;
                    end else if (!r_gy[0]) begin
                        r_gy <= r_gy >> 1;
                    end else if (gx_ge) begin
                        r_gx <= sub_d[WW-1:0];
                    end else begin
                        r_gy <= sub_d[WW-1:0];
                    end
                end
                S_DIV_N: begin
                    r_rem <= rem_next;
                    r_qn  <= {r_qn[WW-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_D;
                    end
                end
                S_DIV_D: begin
                    r_rem <= rem_next;
                    r_qd  <= {r_qd[WW-2:0], q_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_sum_num <= r_nneg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});
                        r_sum_den <= r_dneg ? -$signed(r_qd) : $signed(r_qd);
                        r_out_err <= r_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_sum_num        = r_sum_num;
    assign o_sum_den        = r_sum_den;
    assign o_zero_den_error = r_out_err;

endmodule

// ===== tb/fraction_add_reduce_checker.sv =====
module fraction_sum_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_den_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_b,
    input  logic signed [OPERAND_WIDTH-1:0] i_den_b,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic signed [2*OPERAND_WIDTH:0] i_sum_num,
    input  logic signed [2*OPERAND_WIDTH-1:0] i_sum_den,
    input  logic                            i_zero_den_error,
    input  logic                            i_end_of_run,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = OPERAND_WIDTH;

    typedef struct packed {
        logic signed [2*W:0]   num;
        logic signed [2*W-1:0] den;
        logic                  err;
    } t_frac_sum;

    t_frac_sum sum_q[$];
    t_frac_sum want;
    t_frac_sum got;
    logic      reduce_en;
    int        fails = 0;
    int        checked = 0;
    bit        end_seen = 1'b0;

    function automatic longint unsigned common_divisor(input longint unsigned x,
                                                      input longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Cross-multiplied sum; signs stay where the products put them.
    function automatic t_frac_sum add_fractions(input logic signed [W-1:0] na,
                                                input logic signed [W-1:0] da,
                                                input logic signed [W-1:0] nb,
                                                input logic signed [W-1:0] db,
                                                input logic reduce);
        longint          n;
        longint          d;
        longint unsigned g;
        t_frac_sum       r;
        r = '0;
        if (da == 0 || db == 0) begin
            r.err = 1'b1;
            return r;
        end
        n = longint'(na) * longint'(db) + longint'(da) * longint'(nb);
        d = longint'(da) * longint'(db);
        if (reduce) begin
            g = common_divisor(unsigned'(n < 0 ? -n : n),
                               unsigned'(d < 0 ? -d : d));
            n = n / longint'(g);
            d = d / longint'(g);
        end
        r.num = n[2*W:0];
        r.den = d[2*W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sum_q.delete();
            reduce_en = frac_add_pkg::REDUCE_EN_RESET;
        end else begin
            if (i_cfg_we)
                reduce_en = i_cfg_wdata;

            // check the result first so that a result can never pair with an
            // item that was accepted on the same edge
            if (i_out_valid && !i_out_stall) begin
                got = '{num: i_sum_num, den: i_sum_den, err: i_zero_den_error};
                if (sum_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result num=%0d den=%0d err=%0b",
                                 $realtime, got.num, got.den, got.err);
                end else begin
                    want = sum_q.pop_front();
                    checked++;
                    if (got.num !== want.num || got.den !== want.den ||
                        got.err !== want.err) begin
                        fails++;
                        if (fails <= 10)
                            $display("[%0t] result %0d: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                                     $realtime, checked, want.num, want.den, want.err,
                                     got.num, got.den, got.err);
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                sum_q.push_back(add_fractions(i_num_a, i_den_a, i_num_b, i_den_b,
                                              reduce_en));

            if (i_end_of_run && !end_seen) begin
                end_seen = 1'b1;
                if (sum_q.size() != 0) begin
                    fails += sum_q.size();
                    $display("[%0t] %0d expected results never arrived",
                             $realtime, sum_q.size());
                end
            end
        end
        o_pending    <= sum_q.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = 16;

    // receiver behavior, picked anew at random for each span of the run
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_RUNS,
        STALL_HEAVY
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [OW-1:0] i_num_a = '0;
    logic signed [OW-1:0] i_den_a = '0;
    logic signed [OW-1:0] i_num_b = '0;
    logic signed [OW-1:0] i_den_b = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [2*OW:0] o_sum_num;
    logic signed [2*OW-1:0] o_sum_den;
    logic                 o_zero_den_error;

    logic end_of_run = 1'b0;
    int   pending_sums;
    int   checked_sums;
    int   fail_count;

    int items_sent = 0;
    int zero_den_items = 0;
    int cfg_writes = 0;

    // directed fractions: num_a, den_a, num_b, den_b
    int dir_vec [15][4] = '{
        '{1, 2, 1, 3},                      // plain sum, already reduced
        '{5, 0, 1, 2},                      // first denominator zero
        '{1, 2, 7, 0},                      // second denominator zero
        '{3, 0, -4, 0},                     // both denominators zero
        '{1, 2, 1, -2},                     // zero sum over a negative denominator
        '{1, 2, -1, 2},                     // zero sum over a positive denominator
        '{3, -4, 1, 2},                     // negative denominator survives reduction
        '{-32768, -32768, -32768, -32768},  // largest positive numerator
        '{-32768, 32767, -32768, 32767},    // most negative numerator
        '{32767, 1, 32767, 1},
        '{0, 5, 0, 7},                      // both numerators zero
        '{-1, -1, 0, 1},
        '{32767, -32768, -32768, 32767},
        '{21845, -21846, -1, -1},           // alternating bit patterns
        '{32749, 32719, 1, 32717}           // large coprime terms, long GCD
    };

    fraction_add_reduce #(
        .OPERAND_WIDTH(OW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_num_a         (i_num_a),
        .i_den_a         (i_den_a),
        .i_num_b         (i_num_b),
        .i_den_b         (i_den_b),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sum_num       (o_sum_num),
        .o_sum_den       (o_sum_den),
        .o_zero_den_error(o_zero_den_error)
    );

    fraction_sum_checker #(
        .OPERAND_WIDTH(OW)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_num_a         (i_num_a),
        .i_den_a         (i_den_a),
        .i_num_b         (i_num_b),
        .i_den_b         (i_den_b),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_sum_num       (o_sum_num),
        .i_sum_den       (o_sum_den),
        .i_zero_den_error(o_zero_den_error),
        .i_end_of_run    (end_of_run),
        .o_pending       (pending_sums),
        .o_checked       (checked_sums),
        .o_fail_count    (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop. The slowest correct run (every item reduced, plus the longest
    // sender gap and receiver stall) stays under a third of this.
    initial begin
        #25_000_000;
        $display("[%0t] timeout with %0d sums outstanding", $realtime, pending_sums);
        $display("Mismatches found");
        $finish;
    end

    // Receiver: pick a stall behavior, hold it for a while, then move on.
    // STALL_NONE gives stretches with the output never held back.
    initial begin
        t_stall_mode mode;
        int          span;
        int          run_left;
        bit          stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(50, 400);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE: begin
                        i_out_stall <= 1'b0;
                    end
                    STALL_COIN: begin
                        i_out_stall <= 1'($urandom_range(0, 1));
                    end
                    STALL_RUNS: begin
                        // alternate solid stall and release runs
                        if (run_left == 0) begin
                            stall_now = ~stall_now;
                            run_left  = stall_now ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 20);
                        end
                        run_left--;
                        i_out_stall <= stall_now;
                    end
                    default: begin
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    // Operand that tends to share factors with others, so reduction has work.
    function automatic logic signed [OW-1:0] pick_operand(input bit nonzero);
        int v;
        do begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 4))
                        0: v = -32768;
                        1: v = 32767;
                        2: v = 0;
                        3: v = -1;
                        default: v = 1;
                    endcase
                end
                1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
                4, 5:    v = int'($urandom_range(0, 65535)) - 32768;
                default: v = (int'($urandom_range(0, 200)) - 100) *
                             int'($urandom_range(1, 300));
            endcase
        end while (nonzero && v == 0);
        return v[OW-1:0];
    endfunction

    // Present one pair of fractions and hold it until the transfer. Call
    // right after i_clk rises; valid stays high on return.
    task automatic send_fractions(input logic signed [OW-1:0] na,
                                  input logic signed [OW-1:0] da,
                                  input logic signed [OW-1:0] nb,
                                  input logic signed [OW-1:0] db);
        i_in_valid <= 1'b1;
        i_num_a    <= na;
        i_den_a    <= da;
        i_num_b    <= nb;
        i_den_b    <= db;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_sent++;
        if (da == 0 || db == 0)
            zero_den_items++;
    endtask

    // Let every sum drain, then write reduce_enable.
    task automatic set_reduce(input logic en);
        do @(posedge i_clk); while (pending_sums != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic directed_pass(input int count);
        for (int k = 0; k < count; k++)
            send_fractions(OW'(dir_vec[k][0]), OW'(dir_vec[k][1]),
                           OW'(dir_vec[k][2]), OW'(dir_vec[k][3]));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random bursts: back-to-back items inside a burst, and a gap between bursts
    // so valid is never dropped and raised in one step.
    task automatic random_phase(input int count);
        logic signed [OW-1:0] na, da, nb, db;
        int                   burst;
        int                   left;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                na = pick_operand(1'b0);
                da = pick_operand(1'b1);
                nb = pick_operand(1'b0);
                db = pick_operand(1'b1);
                // occasional zero denominator on either side or both
                if ($urandom_range(0, 39) == 0) begin
                    case ($urandom_range(0, 2))
                        0: da = '0;
                        1: db = '0;
                        default: begin
                            da = '0;
                            db = '0;
                        end
                    endcase
                end
                send_fractions(na, da, nb, db);
            end
            left -= burst;
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset value of reduce_enable first, then raw sums
        directed_pass(15);
        set_reduce(1'b0);
        directed_pass(10);

        // random: alternate reduced and raw phases
        for (int ph = 0; ph < 6; ph++) begin
            set_reduce((ph % 2) == 0);
            random_phase(250);
        end

        // drain, then allow one worst-case item time for anything stray
        do @(posedge i_clk); while (pending_sums != 0);
        repeat (250) @(posedge i_clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Sent %0d fraction pairs (%0d with a zero denominator), %0d sums checked,",
                 items_sent, zero_den_items, checked_sums);
        $display("across %0d reduce_enable writes covering reduced and raw modes.",
                 cfg_writes);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fraction_add_reduce_pkg.sv
sv/fraction_add_reduce.sv
tb/fraction_add_reduce_checker.sv
tb/tb_top.sv
